// ----- rtl/pgs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pgs_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       packet_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       unit_last;
    logic       key_frame;
    logic       corrupt;
  } out_word_t;

  typedef enum logic [4:0] {
    PH_TYPE  = 5'b00001,
    PH_LENHI = 5'b00010,
    PH_LENLO = 5'b00100,
    PH_BODY  = 5'b01000,
    PH_SKIP  = 5'b10000
  } phase_t;

  localparam logic        ACT_DATA         = 1'b0;
  localparam logic        ACT_EOS          = 1'b1;
  localparam logic [7:0]  SEG_PRESENTATION = 8'h16;
  localparam logic [7:0]  SEG_END_SET      = 8'h80;
  localparam logic [7:0]  KEY_MASK         = 8'hC0;
  localparam logic [3:0]  KEY_BODY_INDEX   = 4'd7;
  localparam logic [3:0]  BODY_INDEX_MAX   = 4'd15;
  localparam logic [15:0] MIN_PRES_BODY    = 16'd8;

endpackage

`default_nettype wire

// ----- rtl/pgs_display_set_merger.sv -----
// PGS display-set merger: takes subtitle packet payload one byte per word (with a
// last-byte-of-packet mark, or an end-of-stream word), passes every byte straight
// through and marks the last byte of each display-set unit, which closes on the
// end-of-display-set segment or early on a parse error at packet end. unit_last
// words carry the key flag from the presentation segment and a corrupt flag. An
// end of stream with an open unit yields one byteless, corrupt unit end; with no
// open unit it yields nothing. Throughput is one word per cycle while out_stall is
// low: the segment parse is combinational between the input register and the
// output register, which loads a result when it is empty or not stalled.
`timescale 1ns / 1ps
`default_nettype none

module pgs_display_set_merger (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pgs_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pgs_pkg::out_word_t     out_data
);

  pgs_pkg::in_word_t  item;
  pgs_pkg::out_word_t res;
  logic item_full;
  logic take;
  logic res_valid;
  logic can_load;

  pgs_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .full     (item_full),
    .word     (item)
  );

  pgs_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_full),
    .item       (item),
    .sink_ready (can_load),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  pgs_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_word (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/pgs_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pgs_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pgs_pkg::in_word_t in_data,
  input  wire logic              take,
  output logic                   full,
  output pgs_pkg::in_word_t      word
);

  logic accept;

  assign in_stall = full && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pgs_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pgs_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire pgs_pkg::in_word_t item,
  input  wire logic              sink_ready,
  output logic                   take,
  output logic                   res_valid,
  output pgs_pkg::out_word_t     res
);

  pgs_pkg::phase_t phase, phase_next;
  logic [7:0]  kind, kind_next;
  logic [15:0] body_left, body_left_next;
  logic [3:0]  body_index, body_index_next;
  logic        pending_key, pending_key_next;
  logic        presentation_seen, presentation_seen_next;
  logic        key_flag, key_flag_next;
  logic        corrupt_flag, corrupt_flag_next;
  logic        unit_open, unit_open_next;

  logic        has_result;
  logic        seg_done;
  logic        unit_end;
  logic        bad;
  logic [15:0] bl;
  logic [7:0]  b;

  assign b          = item.data_byte;
  assign has_result = (item.action == pgs_pkg::ACT_DATA) || unit_open;
  assign take       = item_valid && (sink_ready || !has_result);

  always_comb begin
    phase_next             = phase;
    kind_next              = kind;
    body_left_next         = body_left;
    body_index_next        = body_index;
    pending_key_next       = pending_key;
    presentation_seen_next = presentation_seen;
    key_flag_next          = key_flag;
    corrupt_flag_next      = corrupt_flag;
    unit_open_next         = unit_open;
    res_valid              = 1'b0;
    res                    = '0;
    seg_done               = 1'b0;
    unit_end               = 1'b0;
    bad                    = 1'b0;
    bl                     = '0;
    if (take) begin
      if (item.action == pgs_pkg::ACT_EOS) begin
        phase_next = pgs_pkg::PH_TYPE;
        if (unit_open) begin
          res_valid              = 1'b1;
          res.unit_last          = 1'b1;
          res.key_frame          = key_flag;
          res.corrupt            = 1'b1;
          presentation_seen_next = 1'b0;
          key_flag_next          = 1'b0;
          pending_key_next       = 1'b0;
          corrupt_flag_next      = 1'b0;
          unit_open_next         = 1'b0;
        end
      end else begin
        unit_open_next = 1'b1;
        unique case (phase)
          pgs_pkg::PH_TYPE: begin
            kind_next  = b;
            phase_next = pgs_pkg::PH_LENHI;
          end
          pgs_pkg::PH_LENHI: begin
            body_left_next = {b, 8'h00};
            phase_next     = pgs_pkg::PH_LENLO;
          end
          pgs_pkg::PH_LENLO: begin
            bl               = {body_left[15:8], b};
            body_left_next   = bl;
            body_index_next  = '0;
            pending_key_next = 1'b0;
            if (kind == pgs_pkg::SEG_PRESENTATION &&
                (presentation_seen || bl < pgs_pkg::MIN_PRES_BODY)) begin
              corrupt_flag_next = 1'b1;
              phase_next        = pgs_pkg::PH_SKIP;
            end else if (bl == '0) begin
              seg_done = 1'b1;
            end else begin
              phase_next = pgs_pkg::PH_BODY;
            end
          end
          pgs_pkg::PH_BODY: begin
            if (kind == pgs_pkg::SEG_PRESENTATION && body_index == pgs_pkg::KEY_BODY_INDEX) begin
              pending_key_next = |(b & pgs_pkg::KEY_MASK);
            end
            if (body_index != pgs_pkg::BODY_INDEX_MAX) begin
              body_index_next = body_index + 4'd1;
            end
            bl             = body_left - 16'd1;
            body_left_next = bl;
            if (bl == '0) begin
              seg_done = 1'b1;
            end
          end
          default: begin
            phase_next = pgs_pkg::PH_SKIP;
          end
        endcase

        if (seg_done) begin
          phase_next = pgs_pkg::PH_TYPE;
          if (kind == pgs_pkg::SEG_PRESENTATION) begin
            presentation_seen_next = 1'b1;
            key_flag_next          = pending_key_next;
          end
          if (kind == pgs_pkg::SEG_END_SET) begin
            unit_end = 1'b1;
            bad      = !presentation_seen_next;
          end
        end
        if (!unit_end && item.packet_last && phase_next != pgs_pkg::PH_TYPE) begin
          unit_end = 1'b1;
          bad      = 1'b1;
        end

        res_valid      = 1'b1;
        res.out_byte   = b;
        res.byte_valid = 1'b1;
        if (unit_end) begin
          res.unit_last          = 1'b1;
          res.key_frame          = key_flag_next;
          res.corrupt            = bad | corrupt_flag_next;
          phase_next             = pgs_pkg::PH_TYPE;
          presentation_seen_next = 1'b0;
          key_flag_next          = 1'b0;
          pending_key_next       = 1'b0;
          corrupt_flag_next      = 1'b0;
          unit_open_next         = 1'b0;
        end else if (item.packet_last) begin
          phase_next = pgs_pkg::PH_TYPE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= pgs_pkg::PH_TYPE;
      kind              <= '0;
      body_left         <= '0;
      body_index        <= '0;
      pending_key       <= 1'b0;
      presentation_seen <= 1'b0;
      key_flag          <= 1'b0;
      corrupt_flag      <= 1'b0;
      unit_open         <= 1'b0;
    end else begin
      phase             <= phase_next;
      kind              <= kind_next;
      body_left         <= body_left_next;
      body_index        <= body_index_next;
      pending_key       <= pending_key_next;
      presentation_seen <= presentation_seen_next;
      key_flag          <= key_flag_next;
      corrupt_flag      <= corrupt_flag_next;
      unit_open         <= unit_open_next;
    end
  end

  a_mid_unit_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.unit_last |-> !res.key_frame && !res.corrupt)
    else $error("key or corrupt flag set on a word inside a unit");

  a_eos_corrupt: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.byte_valid |-> res.unit_last && res.corrupt)
    else $error("byteless word is not a corrupt unit end");

  a_unit_close: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.unit_last |=> !unit_open && phase == pgs_pkg::PH_TYPE &&
      !presentation_seen && !corrupt_flag && !key_flag)
    else $error("unit state not cleared after unit end");

  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == pgs_pkg::PH_BODY |-> body_left != '0)
    else $error("body phase with no bytes left");

  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    !take |-> !res_valid)
    else $error("result without a taken word");

endmodule

`default_nettype wire

// ----- rtl/pgs_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pgs_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire pgs_pkg::out_word_t load_word,
  output logic                    can_load,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pgs_pkg::out_word_t      out_data
);

  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_word;
    end
  end

endmodule

`default_nettype wire
